@@ hdl/sfru_pkg.sv @@
// shared constants, codes and types of the scanner frame unpacker
package sfru_pkg;

  // default limits of the frame geometry
  localparam int MAX_WIDTH_DEF = 16384;
  localparam int MAX_ROWS_DEF  = 16384;

  // fixed field widths
  localparam int DATA_W    = 8;
  localparam int INDEX_W   = 28;
  localparam int COLOR_W   = 8;
  localparam int LANE_W    = 3;
  localparam int LINE_W    = 15;
  localparam int FMT_W     = 3;
  localparam int DEPTH_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int SLOT_W    = 2;
  localparam int BIT_CNT_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT = 2'd0,
    REG_DEPTH  = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_COUNT  = 2'd3
  } reg_idx_t;

  // frame format codes
  localparam logic [FMT_W-1:0] FMT_GRAY  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_RGB   = 3'd1;
  localparam logic [FMT_W-1:0] FMT_RED   = 3'd2;
  localparam logic [FMT_W-1:0] FMT_GREEN = 3'd3;
  localparam logic [FMT_W-1:0] FMT_BLUE  = 3'd4;

  // sample depth codes
  localparam logic [DEPTH_W-1:0] DEPTH_1   = 2'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_8   = 2'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_16  = 2'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_BAD = 2'd3;

  // next component of an interleaved pixel
  localparam logic [SLOT_W-1:0] SLOT_RED   = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_GREEN = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_BLUE  = 2'd2;

  // lane masks
  localparam logic [LANE_W-1:0] LANES_NONE = 3'b000;
  localparam logic [LANE_W-1:0] LANES_B    = 3'b001;
  localparam logic [LANE_W-1:0] LANES_G    = 3'b010;
  localparam logic [LANE_W-1:0] LANES_R    = 3'b100;
  localparam logic [LANE_W-1:0] LANES_RGB  = 3'b111;

  // one-bit gray levels
  localparam logic [COLOR_W-1:0] WHITE = 8'hFF;
  localparam logic [COLOR_W-1:0] BLACK = 8'h00;

  // register reset values
  localparam logic [FMT_W-1:0]   FORMAT_RST = FMT_GRAY;
  localparam logic [DEPTH_W-1:0] DEPTH_RST  = DEPTH_16;
  localparam logic [LINE_W-1:0]  WIDTH_RST  = 15'd1;
  localparam logic [LINE_W-1:0]  COUNT_RST  = 15'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOM,
    ST_MUL,
    ST_EMIT,
    ST_FAULT
  } state_t;

endpackage

@@ hdl/scanner_frame_to_rgb32_unpacker_core.sv @@
// top level of the scanner frame unpacker: byte in, rgb32 pixel writes out

// Takes raw scan data one byte per beat and produces pixel writes for an
// RGB32 frame buffer: 1-bit gray (msb first, set bit is black), 8- and
// 16-bit gray (16-bit keeps the second byte of each sample), interleaved
// rgb, and single red, green or blue planes that write only their lane.
// A byte that is skipped (even byte of a 16-bit sample), held (first two
// components of an rgb pixel) or a begin-frame command is done once it is
// accepted. A byte that writes pixels is accepted, the frame height is
// checked and grown, then row * width + column is formed by a bit-serial
// shift-and-add over the row number, one row bit per cycle, then the
// pixels are written one per cycle while the output is not stalled.
// Refused bytes give one error beat. One item is worked on at a time; a
// finished beat waits in the output register while the next byte is
// accepted. Configuration writes are always ready and must only happen
// while the block is idle.
module scanner_frame_to_rgb32_unpacker_core #(
  parameter int MAX_WIDTH = sfru_pkg::MAX_WIDTH_DEF,
  parameter int MAX_ROWS  = sfru_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input beats
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                command,
  input  logic [sfru_pkg::DATA_W-1:0]         data_byte,
  // output beats
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sfru_pkg::INDEX_W-1:0]        pixel_index,
  output logic [sfru_pkg::COLOR_W-1:0]        red,
  output logic [sfru_pkg::COLOR_W-1:0]        green,
  output logic [sfru_pkg::COLOR_W-1:0]        blue,
  output logic [sfru_pkg::LANE_W-1:0]         lane_mask,
  output logic [sfru_pkg::LINE_W-1:0]         image_rows,
  output logic                                grew,
  output logic                                error,
  output logic                                last,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfru_pkg::LINE_W-1:0]         cfg_data
);

  // effective width holds 1..MAX_WIDTH, a column 0..MAX_WIDTH-1
  localparam int EW     = $clog2(MAX_WIDTH + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  // a row can sit one past the last frame row
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int PROD_W = ROW_W + EW;
  localparam int SUM_W  = ((ROW_W > EW) ? ROW_W : EW) + 1;
  localparam logic [31:0] MAX_W_L = 32'(MAX_WIDTH);
  localparam logic [31:0] MAX_R_L = 32'(MAX_ROWS);

  // configuration registers
  logic [sfru_pkg::FMT_W-1:0]   frame_format;
  logic [sfru_pkg::DEPTH_W-1:0] sample_depth;
  logic [sfru_pkg::LINE_W-1:0]  line_width;
  logic [sfru_pkg::LINE_W-1:0]  line_count;

  // frame position state
  sfru_pkg::state_t             state, state_next;
  logic [COL_W-1:0]             pixel_col;
  logic [ROW_W-1:0]             pixel_row;
  logic [ROW_W-1:0]             frame_rows;
  logic [sfru_pkg::SLOT_W-1:0]  channel_slot;
  logic                         byte_odd;     // only the parity of the byte count is ever used
  logic [sfru_pkg::COLOR_W-1:0] held_red;
  logic [sfru_pkg::COLOR_W-1:0] held_green;

  // per byte work registers
  logic [sfru_pkg::DATA_W-1:0]    data_shift;
  logic [sfru_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic                           grew_flag;
  logic [PROD_W-1:0]              acc;
  logic [PROD_W-1:0]              mcand;
  logic [ROW_W-1:0]               mplier;

  // control
  logic in_accept;
  logic slot_free;
  logic load_pix;
  logic load_err;
  logic bad_mode;
  logic skip_even;
  logic hold_rgb;

  // geometry
  logic [EW-1:0]    eff_w;
  logic [31:0]      nom_raw;
  logic [ROW_W-1:0] nom_rows;
  logic [SUM_W-1:0] grow_sum;
  logic [ROW_W-1:0] grow_rows;
  logic [ROW_W-1:0] room_rows;
  logic             room_grew;
  logic             room_ok;
  logic [EW-1:0]    col_inc;
  logic             wrap;
  logic [ROW_W-1:0] row_adv;
  logic [COL_W-1:0] col_adv;
  logic             lines_stop;
  logic             last_pix;

  // pixel values of this write
  logic [sfru_pkg::COLOR_W-1:0] pix_r, pix_g, pix_b, bit_level;
  logic [sfru_pkg::LANE_W-1:0]  pix_lanes;

  assign cfg_ready = 1'b1;

  // width of 0 acts as 1, clamp at the width limit
  always_comb begin
    if (line_width == '0) begin
      eff_w = EW'(1);
    end else if (32'(line_width) > MAX_W_L) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(line_width);
    end
  end

  // nominal height reloaded at begin frame
  always_comb begin
    nom_raw  = (line_count == '0) ? 32'(eff_w) : 32'(line_count);
    nom_rows = (nom_raw > MAX_R_L) ? ROW_W'(MAX_ROWS) : ROW_W'(nom_raw);
  end

  // make room for the current row: grow by one line width, saturating
  always_comb begin
    grow_sum  = SUM_W'(frame_rows) + SUM_W'(eff_w);
    grow_rows = (grow_sum > SUM_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : ROW_W'(grow_sum);
    room_rows = (pixel_row < frame_rows) ? frame_rows : grow_rows;
    room_grew = (room_rows != frame_rows);
    room_ok   = (pixel_row < room_rows);
  end

  // advance one pixel; a column beyond a shrunk width wraps here too
  always_comb begin
    col_inc    = EW'(pixel_col) + EW'(1);
    wrap       = (col_inc >= eff_w);
    row_adv    = wrap ? (pixel_row + ROW_W'(1)) : pixel_row;
    col_adv    = wrap ? '0 : COL_W'(col_inc);
    lines_stop = (line_count != '0) && (32'(row_adv) >= 32'(line_count));
  end

  // byte classification at accept
  always_comb begin
    bad_mode  = (frame_format > sfru_pkg::FMT_BLUE) ||
                (sample_depth == sfru_pkg::DEPTH_BAD) ||
                ((sample_depth == sfru_pkg::DEPTH_1) && (frame_format != sfru_pkg::FMT_GRAY));
    skip_even = (sample_depth == sfru_pkg::DEPTH_16) && !byte_odd;
    hold_rgb  = (frame_format == sfru_pkg::FMT_RGB) && (channel_slot != sfru_pkg::SLOT_BLUE);
  end

  // colors of the write in progress
  always_comb begin
    bit_level = data_shift[sfru_pkg::DATA_W-1] ? sfru_pkg::BLACK : sfru_pkg::WHITE;
    pix_r     = data_shift;
    pix_g     = data_shift;
    pix_b     = data_shift;
    pix_lanes = sfru_pkg::LANES_RGB;
    if (sample_depth == sfru_pkg::DEPTH_1) begin
      pix_r = bit_level;
      pix_g = bit_level;
      pix_b = bit_level;
    end else begin
      case (frame_format)
        sfru_pkg::FMT_RGB: begin
          pix_r = held_red;
          pix_g = held_green;
        end
        sfru_pkg::FMT_RED: begin
          pix_g     = '0;
          pix_b     = '0;
          pix_lanes = sfru_pkg::LANES_R;
        end
        sfru_pkg::FMT_GREEN: begin
          pix_r     = '0;
          pix_b     = '0;
          pix_lanes = sfru_pkg::LANES_G;
        end
        sfru_pkg::FMT_BLUE: begin
          pix_r     = '0;
          pix_g     = '0;
          pix_lanes = sfru_pkg::LANES_B;
        end
        default: begin
        end
      endcase
    end
    // one-bit bytes stop at line end, at the expected line count, or after bit 0
    last_pix = (sample_depth != sfru_pkg::DEPTH_1) || wrap || lines_stop ||
               (bit_cnt == sfru_pkg::BIT_CNT_W'(sfru_pkg::DATA_W - 1));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sfru_pkg::ST_IDLE: begin
        if (in_accept && !command) begin
          if (bad_mode) begin
            state_next = sfru_pkg::ST_FAULT;
          end else if (!skip_even && !hold_rgb) begin
            state_next = sfru_pkg::ST_ROOM;
          end
        end
      end
      sfru_pkg::ST_ROOM: begin
        state_next = room_ok ? sfru_pkg::ST_MUL : sfru_pkg::ST_FAULT;
      end
      sfru_pkg::ST_MUL: begin
        if (mplier == '0) begin
          state_next = sfru_pkg::ST_EMIT;
        end
      end
      sfru_pkg::ST_EMIT: begin
        if (slot_free && last_pix) begin
          state_next = sfru_pkg::ST_IDLE;
        end
      end
      sfru_pkg::ST_FAULT: begin
        if (slot_free) begin
          state_next = sfru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sfru_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state != sfru_pkg::ST_IDLE);
    in_accept = in_valid && !in_stall;
    slot_free = !out_valid || !out_stall;
    load_pix  = (state == sfru_pkg::ST_EMIT) && slot_free;
    load_err  = (state == sfru_pkg::ST_FAULT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_format <= sfru_pkg::FORMAT_RST;
      sample_depth <= sfru_pkg::DEPTH_RST;
      line_width   <= sfru_pkg::WIDTH_RST;
      line_count   <= sfru_pkg::COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfru_pkg::REG_FORMAT: frame_format <= cfg_data[sfru_pkg::FMT_W-1:0];
        sfru_pkg::REG_DEPTH:  sample_depth <= cfg_data[sfru_pkg::DEPTH_W-1:0];
        sfru_pkg::REG_WIDTH:  line_width   <= cfg_data;
        sfru_pkg::REG_COUNT:  line_count   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // frame position, component slot and byte parity
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_col    <= '0;
      pixel_row    <= '0;
      channel_slot <= sfru_pkg::SLOT_RED;
      byte_odd     <= 1'b0;
      held_red     <= '0;
      held_green   <= '0;
      // line count resets to zero, so the height starts at the reset width
      frame_rows   <= ROW_W'(sfru_pkg::WIDTH_RST);
    end else begin
      if (in_accept) begin
        if (command) begin
          pixel_col    <= '0;
          pixel_row    <= '0;
          channel_slot <= sfru_pkg::SLOT_RED;
          byte_odd     <= 1'b0;
          frame_rows   <= nom_rows;
        end else if (!bad_mode && skip_even) begin
          byte_odd <= !byte_odd;
        end else if (!bad_mode && hold_rgb) begin
          byte_odd <= !byte_odd;
          if (channel_slot == sfru_pkg::SLOT_GREEN) begin
            held_green   <= data_byte;
            channel_slot <= sfru_pkg::SLOT_BLUE;
          end else begin
            held_red     <= data_byte;
            channel_slot <= sfru_pkg::SLOT_GREEN;
          end
        end
      end
      // growth sticks even when the byte is then refused
      if (state == sfru_pkg::ST_ROOM) begin
        frame_rows <= room_rows;
      end
      if (load_pix) begin
        pixel_col <= col_adv;
        pixel_row <= row_adv;
        if (last_pix) begin
          byte_odd <= !byte_odd;
          if (frame_format == sfru_pkg::FMT_RGB) begin
            channel_slot <= sfru_pkg::SLOT_RED;
          end
        end
      end
    end
  end

  // per byte datapath: serial row * width + column, then one pixel per cycle while the output is not stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt   <= '0;
      grew_flag <= 1'b0;
    end else begin
      if (in_accept) begin
        grew_flag <= 1'b0;
      end
      if (state == sfru_pkg::ST_ROOM) begin
        grew_flag <= room_grew;
        bit_cnt   <= '0;
      end
      if (load_pix) begin
        grew_flag <= 1'b0;
        bit_cnt   <= bit_cnt + sfru_pkg::BIT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      data_shift <= data_byte;
    end
    if (state == sfru_pkg::ST_ROOM) begin
      acc    <= PROD_W'(pixel_col);
      mcand  <= PROD_W'(eff_w);
      mplier <= pixel_row;
    end
    if ((state == sfru_pkg::ST_MUL) && (mplier != '0)) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
    if (load_pix) begin
      // next pixel of the same byte is always the following address
      acc        <= acc + PROD_W'(1);
      data_shift <= data_shift << 1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_pix || load_err) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pix) begin
      pixel_index <= sfru_pkg::INDEX_W'(acc);
      red         <= pix_r;
      green       <= pix_g;
      blue        <= pix_b;
      lane_mask   <= pix_lanes;
      image_rows  <= sfru_pkg::LINE_W'(frame_rows);
      grew        <= grew_flag;
      error       <= 1'b0;
      last        <= last_pix;
    end else if (load_err) begin
      pixel_index <= '0;
      red         <= '0;
      green       <= '0;
      blue        <= '0;
      lane_mask   <= sfru_pkg::LANES_NONE;
      image_rows  <= sfru_pkg::LINE_W'(frame_rows);
      grew        <= grew_flag;
      error       <= 1'b1;
      last        <= 1'b1;
    end
  end

endmodule

@@ hdl/sfru_checker.sv @@
// port-level checks of the scanner frame unpacker, bound to the top level
module sfru_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [sfru_pkg::INDEX_W-1:0]   pixel_index,
  input logic [sfru_pkg::COLOR_W-1:0]   red,
  input logic [sfru_pkg::COLOR_W-1:0]   green,
  input logic [sfru_pkg::COLOR_W-1:0]   blue,
  input logic [sfru_pkg::LANE_W-1:0]    lane_mask,
  input logic                           error,
  input logic                           last
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_index) &&
      $stable(lane_mask) && $stable(last))
    else $error("output beat changed under stall");

  // refused byte gives a single empty beat
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last && (pixel_index == '0) &&
      (lane_mask == sfru_pkg::LANES_NONE) && (red == '0) && (green == '0) && (blue == '0))
    else $error("error beat carries data");

  // every pixel write touches at least one lane
  a_pix_lanes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error |-> (lane_mask != sfru_pkg::LANES_NONE))
    else $error("pixel write with no lanes");

  // red plane: one beat per byte, other lanes zero
  a_red_plane: assert property (@(posedge clk) disable iff (rst)
    out_valid && (lane_mask == sfru_pkg::LANES_R) |-> last && (green == '0) && (blue == '0))
    else $error("red plane write malformed");

endmodule

bind scanner_frame_to_rgb32_unpacker_core sfru_checker u_sfru_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pixel_index (pixel_index),
  .red         (red),
  .green       (green),
  .blue        (blue),
  .lane_mask   (lane_mask),
  .error       (error),
  .last        (last)
);

@@ dv/sfru_sb_pkg.sv @@
`timescale 1ns / 1ps
// pixel write scoreboard with its own unpacking predictor for the frame unpacker
package sfru_sb_pkg;
  import sfru_pkg::*;

  localparam int unsigned MAX_W = MAX_WIDTH_DEF;
  localparam int unsigned MAX_R = MAX_ROWS_DEF;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [LANE_W-1:0]  lanes;
    logic [LINE_W-1:0]  rows;
    logic               grew;
    logic               err;
    logic               last;
  } pixel_write_t;

  class pixel_write_board;
    // register copies
    logic [FMT_W-1:0]   fmt;
    logic [DEPTH_W-1:0] depth;
    int unsigned        width_reg;
    int unsigned        count_reg;
    // unpacker state
    logic [28:0]        byte_count;
    int unsigned        col;
    int unsigned        row;
    int unsigned        frame_rows;
    logic [SLOT_W-1:0]  slot;
    logic [COLOR_W-1:0] held_r;
    logic [COLOR_W-1:0] held_g;

    pixel_write_t pending_writes[$];
    int unsigned n_bytes, n_writes, n_refused, n_cfg, n_mismatch, tallest;

    function new();
      fmt        = FORMAT_RST;
      depth      = DEPTH_RST;
      width_reg  = 32'(WIDTH_RST);
      count_reg  = 32'(COUNT_RST);
      byte_count = '0;
      col        = 0;
      row        = 0;
      slot       = SLOT_RED;
      held_r     = '0;
      held_g     = '0;
      frame_rows = nominal_rows();
      tallest    = frame_rows;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned nominal_rows();
      int unsigned n;
      n = (count_reg == 0) ? eff_width() : count_reg;
      if (n > MAX_R) n = MAX_R;
      return n;
    endfunction

    function int unsigned at_pixel();
      return row * eff_width() + col;
    endfunction

    // grow the frame by one line width when the row falls outside it
    function bit grow_frame(output bit grown);
      int unsigned n;
      grown = 1'b0;
      if (row < frame_rows) return 1'b1;
      n = frame_rows + eff_width();
      if (n > MAX_R) n = MAX_R;
      if (n != frame_rows) begin
        frame_rows = n;
        grown      = 1'b1;
      end
      if (frame_rows > tallest) tallest = frame_rows;
      return row < frame_rows;
    endfunction

    // returns 1 when a line was finished
    function bit step_pixel();
      col++;
      if (col >= eff_width()) begin
        col = 0;
        row++;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void add_write(int unsigned at, logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                            logic [COLOR_W-1:0] b, logic [LANE_W-1:0] lanes, bit grown,
                            bit err, bit last);
      pixel_write_t w;
      w.index = at[INDEX_W-1:0];
      w.red   = r;
      w.green = g;
      w.blue  = b;
      w.lanes = lanes;
      w.rows  = frame_rows[LINE_W-1:0];
      w.grew  = grown;
      w.err   = err;
      w.last  = last;
      if (err) n_refused++;
      pending_writes.push_back(w);
    endfunction

    function void set_reg(reg_idx_t idx, logic [LINE_W-1:0] val);
      n_cfg++;
      case (idx)
        REG_FORMAT: fmt = val[FMT_W-1:0];
        REG_DEPTH:  depth = val[DEPTH_W-1:0];
        REG_WIDTH:  width_reg = 32'(val);
        default:    count_reg = 32'(val);
      endcase
    endfunction

    // works out the pixel writes that one accepted beat causes
    function void unpack_byte(bit cmd, logic [DATA_W-1:0] data);
      bit                 grown;
      bit                 done;
      logic [COLOR_W-1:0] v;
      int unsigned        at;
      int                 j;
      n_bytes++;
      if (cmd) begin
        byte_count = '0;
        col        = 0;
        row        = 0;
        slot       = SLOT_RED;
        frame_rows = nominal_rows();
        if (frame_rows > tallest) tallest = frame_rows;
        return;
      end
      if (fmt > FMT_BLUE || depth == DEPTH_BAD || (depth == DEPTH_1 && fmt != FMT_GRAY)) begin
        add_write(0, '0, '0, '0, LANES_NONE, 1'b0, 1'b1, 1'b1);
        return;
      end
      if (depth == DEPTH_16 && !byte_count[0]) begin
        byte_count++;
        return;
      end
      if (depth == DEPTH_1) begin
        if (!grow_frame(grown)) begin
          add_write(0, '0, '0, '0, LANES_NONE, grown, 1'b1, 1'b1);
          return;
        end
        for (j = 7; j >= 0; j--) begin
          v    = data[j] ? BLACK : WHITE;
          at   = at_pixel();
          done = step_pixel() || j == 0 || (count_reg != 0 && row >= count_reg);
          add_write(at, v, v, v, LANES_RGB, grown, 1'b0, done);
          grown = 1'b0;
          if (done) break;
        end
        byte_count++;
        return;
      end
      if (fmt == FMT_RGB && slot != SLOT_BLUE) begin
        if (slot == SLOT_GREEN) begin
          held_g = data;
          slot   = SLOT_BLUE;
        end else begin
          held_r = data;
          slot   = SLOT_GREEN;
        end
        byte_count++;
        return;
      end
      if (!grow_frame(grown)) begin
        add_write(0, '0, '0, '0, LANES_NONE, grown, 1'b1, 1'b1);
        return;
      end
      at = at_pixel();
      case (fmt)
        FMT_RGB:   add_write(at, held_r, held_g, data, LANES_RGB, grown, 1'b0, 1'b1);
        FMT_RED:   add_write(at, data, '0, '0, LANES_R, grown, 1'b0, 1'b1);
        FMT_GREEN: add_write(at, '0, data, '0, LANES_G, grown, 1'b0, 1'b1);
        FMT_BLUE:  add_write(at, '0, '0, data, LANES_B, grown, 1'b0, 1'b1);
        default:   add_write(at, data, data, data, LANES_RGB, grown, 1'b0, 1'b1);
      endcase
      void'(step_pixel());
      if (fmt == FMT_RGB) slot = SLOT_RED;
      byte_count++;
    endfunction

    function string show(pixel_write_t w);
      return $sformatf("idx=%0d rgb=%02h/%02h/%02h lanes=%b rows=%0d grew=%b err=%b last=%b",
                       w.index, w.red, w.green, w.blue, w.lanes, w.rows, w.grew, w.err,
                       w.last);
    endfunction

    function void check_write(pixel_write_t got);
      pixel_write_t want;
      string        bad;
      n_writes++;
      if (pending_writes.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("pixel write %0d with nothing pending: %s", n_writes,
                                       show(got));
        return;
      end
      want = pending_writes.pop_front();
      bad  = "";
      if (got.index !== want.index) bad = {bad, " index"};
      if (got.red   !== want.red)   bad = {bad, " red"};
      if (got.green !== want.green) bad = {bad, " green"};
      if (got.blue  !== want.blue)  bad = {bad, " blue"};
      if (got.lanes !== want.lanes) bad = {bad, " lanes"};
      if (got.rows  !== want.rows)  bad = {bad, " rows"};
      if (got.grew  !== want.grew)  bad = {bad, " grew"};
      if (got.err   !== want.err)   bad = {bad, " error"};
      if (got.last  !== want.last)  bad = {bad, " last"};
      if (bad != "") begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("pixel write %0d differs in%s", n_writes, bad);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function int unsigned outstanding();
      return pending_writes.size();
    endfunction

    function bit clean();
      return n_mismatch == 0 && pending_writes.size() == 0;
    endfunction
  endclass

endpackage

@@ dv/tb_scanner_frame_to_rgb32_unpacker_core.sv @@
`timescale 1ns / 1ps
// top-level testbench: byte beats and register writes in, pixel writes checked out
module tb_scanner_frame_to_rgb32_unpacker_core;
  import sfru_pkg::*;
  import sfru_sb_pkg::*;

  // room for the longest byte (deep-row multiply plus eight writes) and the output register
  localparam int DRAIN_CYCLES  = 40;
  // receiver hold-off long enough to back the block up into its input
  localparam int LONG_HOLD     = 300;
  // the limit leaves a clean run room to spare even when every byte
  // writes eight pixels under the longest stalls
  localparam int CYCLE_LIMIT   = 500_000;
  // width 3 one-bit frame: one line per byte, the height grows every third line
  localparam int DEEP_BYTES    = 80;
  localparam int RANDOM_FRAMES = 12;
  localparam int FRAME_BEATS   = 30;
  localparam int unsigned LINE_MAX = (1 << LINE_W) - 1;
  // highest format code the register can hold, unsupported
  localparam logic [FMT_W-1:0] FMT_TOP = '1;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 command;
  logic [DATA_W-1:0]    data_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [INDEX_W-1:0]   pixel_index;
  logic [COLOR_W-1:0]   red;
  logic [COLOR_W-1:0]   green;
  logic [COLOR_W-1:0]   blue;
  logic [LANE_W-1:0]    lane_mask;
  logic [LINE_W-1:0]    image_rows;
  logic                 grew;
  logic                 error;
  logic                 last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LINE_W-1:0]    cfg_data;

  // calm: neither side idles; hold_req: receiver should back off for a long stretch
  bit               calm;
  bit               hold_req;
  int unsigned      cycle_count;
  pixel_write_board board;

  scanner_frame_to_rgb32_unpacker_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_index (pixel_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .lane_mask   (lane_mask),
    .image_rows  (image_rows),
    .grew        (grew),
    .error       (error),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // receiver side: random stall bursts, one long hold on request, none when calm
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
    end
  end

  // every beat the receiver takes is checked against the oldest pending write
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_write('{index: pixel_index, red: red, green: green, blue: blue,
                          lanes: lane_mask, rows: image_rows, grew: grew, err: error,
                          last: last});
  end

  // one input beat; valid stays up so back-to-back beats need no extra cycle
  task automatic send_beat(bit cmd, logic [DATA_W-1:0] data);
    @(negedge clk);
    in_valid  = 1'b1;
    command   = cmd;
    data_byte = data;
    do @(posedge clk); while (in_stall);
    board.unpack_byte(cmd, data);
  endtask

  task automatic pause_input(int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // all pending writes seen, then a margin for bytes that give none
  task automatic wait_idle();
    pause_input(1);
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [LINE_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // program all four registers while idle, optionally open a new frame
  task automatic setup_frame(logic [FMT_W-1:0] fmt, logic [DEPTH_W-1:0] depth,
                             int unsigned width, int unsigned count, bit restart);
    wait_idle();
    write_reg(REG_FORMAT, LINE_W'(fmt));
    write_reg(REG_DEPTH, LINE_W'(depth));
    write_reg(REG_WIDTH, LINE_W'(width));
    write_reg(REG_COUNT, LINE_W'(count));
    if (restart) send_beat(1'b1, DATA_W'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [FMT_W-1:0]   f;
    logic [DEPTH_W-1:0] d;
    int unsigned        w;
    int unsigned        c;
    int unsigned        pick;
    board     = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    command   = 1'b0;
    data_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_FORMAT;
    cfg_data  = '0;
    calm      = 1'b1;
    hold_req  = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // reset settings: 16-bit gray at width 1, even bytes only counted, second line grows
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, 8'hA5);
    send_beat(1'b0, 8'h5A);

    // one-bit gray, width 5, two lines: rest of byte dropped at line end,
    // past the line count each byte writes a single pixel
    setup_frame(FMT_GRAY, DEPTH_1, 5, 2, 1'b1);
    send_beat(1'b0, 8'hA5);
    send_beat(1'b0, 8'h3C);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, 8'h00);

    // interleaved rgb: two components held, third writes the pixel
    setup_frame(FMT_RGB, DEPTH_8, 2, 0, 1'b1);
    send_beat(1'b0, 8'h11);
    send_beat(1'b0, 8'h22);
    send_beat(1'b0, 8'h33);

    // single planes touch only their own lane
    setup_frame(FMT_RED, DEPTH_16, 4, 0, 1'b1);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hFF);
    setup_frame(FMT_GREEN, DEPTH_8, 4, 0, 1'b0);
    send_beat(1'b0, 8'h80);
    setup_frame(FMT_BLUE, DEPTH_8, 4, 0, 1'b0);
    send_beat(1'b0, 8'h7F);

    // refused modes: bad format, bad depth, one bit with a color format
    setup_frame(FMT_TOP, DEPTH_8, 4, 0, 1'b0);
    send_beat(1'b0, 8'h55);
    setup_frame(FMT_GRAY, DEPTH_BAD, 4, 0, 1'b0);
    send_beat(1'b0, 8'hAA);
    setup_frame(FMT_RGB, DEPTH_1, 4, 0, 1'b0);
    send_beat(1'b0, 8'h0F);

    // zero width acts as one, oversized line count saturates the height
    setup_frame(FMT_GRAY, DEPTH_8, 0, LINE_MAX, 1'b1);
    send_beat(1'b0, 8'hC3);
    // oversized width clamps; then shrink the width with the column beyond it
    setup_frame(FMT_GRAY, DEPTH_8, LINE_MAX, 0, 1'b1);
    send_beat(1'b0, 8'h01);
    send_beat(1'b0, 8'h02);
    send_beat(1'b0, 8'h04);
    setup_frame(FMT_GRAY, DEPTH_8, 2, 0, 1'b0);
    send_beat(1'b0, 8'h08);

    // deep frame: height grows by one line width again and again
    setup_frame(FMT_GRAY, DEPTH_1, 3, 0, 1'b1);
    repeat (DEEP_BYTES) send_beat(1'b0, DATA_W'($urandom_range(0, 255)));

    // random frames: mostly well-formed modes with random content, some refused ones,
    // an occasional begin frame in the middle of a stream
    calm = 1'b0;
    for (int fr = 0; fr < RANDOM_FRAMES; fr++) begin
      if ($urandom_range(0, 9) == 0) f = FMT_W'($urandom_range(FMT_BLUE + 1, FMT_TOP));
      else f = FMT_W'($urandom_range(FMT_GRAY, FMT_BLUE));
      pick = $urandom_range(0, 9);
      if (pick < 3) d = DEPTH_1;
      else if (pick < 6) d = DEPTH_8;
      else if (pick < 9) d = DEPTH_16;
      else d = DEPTH_BAD;
      // keep one-bit frames mostly gray so they get past the mode check
      if (d == DEPTH_1 && f <= FMT_BLUE && $urandom_range(0, 3) != 0) f = FMT_GRAY;
      pick = $urandom_range(0, 15);
      if (pick == 0) w = 0;
      else if (pick == 1) w = MAX_WIDTH_DEF;
      else if (pick == 2) w = $urandom_range(MAX_WIDTH_DEF + 1, LINE_MAX);
      else w = $urandom_range(1, 24);
      pick = $urandom_range(0, 9);
      if (pick < 5) c = 0;
      else if (pick < 8) c = $urandom_range(1, 6);
      else if (pick == 8) c = MAX_ROWS_DEF;
      else c = $urandom_range(MAX_ROWS_DEF + 1, LINE_MAX);
      // last stretch runs with no idling on either side
      if (fr >= RANDOM_FRAMES - 2) calm = 1'b1;
      setup_frame(f, d, w, c, 1'b1);
      // second frame: receiver backs off while beats keep coming
      if (fr == 1) hold_req = 1'b1;
      for (int i = 0; i < FRAME_BEATS; i++) begin
        if (!calm && !hold_req && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 15));
        pick = $urandom_range(0, 7);
        if ($urandom_range(0, 24) == 0) send_beat(1'b1, DATA_W'($urandom_range(0, 255)));
        else if (pick == 0) send_beat(1'b0, 8'h00);
        else if (pick == 1) send_beat(1'b0, 8'hFF);
        else send_beat(1'b0, DATA_W'($urandom_range(0, 255)));
      end
    end

    wait_idle();
    $display("run covered %0d input beats and %0d register writes over all formats and depths",
             board.n_bytes, board.n_cfg);
    $display("%0d pixel writes checked, %0d refused bytes, tallest frame %0d rows, %0d mismatches",
             board.n_writes, board.n_refused, board.tallest, board.n_mismatch);
    if (board.clean()) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
